// File: sv/tkst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_pkg
// Shared types and constants for the top-k score table.
// ----------------------------------------------------------------------------
package tkst_pkg;

  localparam int SCORE_W  = 31;
  localparam int ROOMS_W  = 16;
  localparam int STAMP_W  = 32;
  localparam int NAME_W   = 16;
  localparam int SLOT_W   = 4;
  localparam int PLACE_W  = 4;
  localparam int LATEST_W = 5;

  localparam logic [LATEST_W-1:0] LATEST_NONE = '1;

  typedef enum logic [1:0] {
    OP_OFFER      = 2'd0,
    OP_READ       = 2'd1,
    OP_CLEAR_ALL  = 2'd2,
    OP_CLEAR_TAIL = 2'd3
  } op_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ROOMS_W-1:0] rooms;
    logic [STAMP_W-1:0] stamp;
    logic [NAME_W-1:0]  name;
  } rec_t;

  typedef struct packed {
    logic               placed;
    logic [PLACE_W-1:0] place;
    rec_t               entry;
    logic               is_latest;
  } res_t;

endpackage

// File: sv/tkst_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_table
// Register table of ranked records: parallel compare, one-step shift insert,
// clears, and the read mux. Result is combinational from current state.
// ----------------------------------------------------------------------------
module tkst_table #(
  parameter int ENTRIES = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        upd,
  input  tkst_pkg::op_t               op,
  input  tkst_pkg::rec_t              rec,
  input  logic                        resumed,
  input  logic [tkst_pkg::SLOT_W-1:0] slot,
  output tkst_pkg::res_t              res
);
  import tkst_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CMP_W = IDX_W + SLOT_W + 1;

  rec_t                tbl      [ENTRIES];
  rec_t                tbl_next [ENTRIES];
  rec_t                shifted  [ENTRIES];
  logic [LATEST_W-1:0] latest;
  logic [LATEST_W-1:0] latest_next;

  logic [ENTRIES-1:0]  gt;
  logic [ENTRIES-1:0]  gt_prev;
  logic                found;
  logic [IDX_W-1:0]    pos;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_ok;

  // Table stays descending, so gt is a thermometer: first set bit is the slot.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      gt[i] = rec.score > tbl[i].score;
    end
    gt_prev = {gt[ENTRIES-2:0], 1'b0};
    found   = |gt;
    pos     = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (gt[i]) begin
        pos = IDX_W'(i);
      end
    end
  end

  always_comb begin
    shifted[0] = rec;
    for (int i = 1; i < ENTRIES; i++) begin
      shifted[i] = tbl[i-1];
    end
  end

  always_comb begin
    latest_next = latest;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_next[i] = tbl[i];
    end
    case (op)
      OP_OFFER: begin
        if (!resumed) begin
          latest_next = found ? LATEST_W'(pos) : LATEST_NONE;
          for (int i = 0; i < ENTRIES; i++) begin
            if (gt[i]) begin
              tbl_next[i] = gt_prev[i] ? shifted[i] : rec;
            end
          end
        end
      end
      OP_READ: begin
      end
      OP_CLEAR_ALL: begin
        for (int i = 0; i < ENTRIES; i++) begin
          tbl_next[i] = '0;
        end
      end
      OP_CLEAR_TAIL: begin
        for (int i = 1; i < ENTRIES; i++) begin
          tbl_next[i] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latest <= LATEST_NONE;
      for (int i = 0; i < ENTRIES; i++) begin
        tbl[i] <= '0;
      end
    end else if (upd) begin
      latest <= latest_next;
      for (int i = 0; i < ENTRIES; i++) begin
        tbl[i] <= tbl_next[i];
      end
    end
  end

  assign rd_ok  = CMP_W'(slot) < CMP_W'(ENTRIES);
  assign rd_idx = IDX_W'(slot);

  always_comb begin
    res = '0;
    case (op)
      OP_OFFER: begin
        if (!resumed && found) begin
          res.placed = 1'b1;
          res.place  = PLACE_W'(pos);
        end
      end
      OP_READ: begin
        if (rd_ok) begin
          res.entry     = tbl[rd_idx];
          res.is_latest = latest == LATEST_W'(slot);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/top_k_score_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_score_table
// Best-first table of score records with offer, read and clear operations.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one op word: offer a scored
// record, read an entry, clear all, or clear all but the top entry.
// Output channel (out_valid / out_stall) returns one result word per input
// word, in order.
// The table is updated and the result register loaded at the edge that
// accepts the word.
// Throughput: 1 word per cycle while in_stall is low; the compare-and-shift
// spans all ENTRIES table registers.
// A result waiting under out_stall is held; in_stall rises only while a
// result is held and stalled, so a word is taken in the same cycle the
// previous result drains.
// Reset clears every table entry to zero, marks no latest insert, and
// empties the result register.
// ----------------------------------------------------------------------------
module top_k_score_table #(
  parameter int ENTRIES = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [tkst_pkg::SCORE_W-1:0]  new_score,
  input  logic [tkst_pkg::ROOMS_W-1:0]  rooms,
  input  logic [tkst_pkg::STAMP_W-1:0]  stamp,
  input  logic [tkst_pkg::NAME_W-1:0]   name_tag,
  input  logic                          resumed,
  input  logic [tkst_pkg::SLOT_W-1:0]   slot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          placed,
  output logic [tkst_pkg::PLACE_W-1:0]  place,
  output logic [tkst_pkg::SCORE_W-1:0]  entry_score,
  output logic [tkst_pkg::ROOMS_W-1:0]  entry_rooms,
  output logic [tkst_pkg::STAMP_W-1:0]  entry_stamp,
  output logic [tkst_pkg::NAME_W-1:0]   entry_name,
  output logic                          is_latest
);
  import tkst_pkg::*;

  logic accept;
  rec_t rec;
  res_t res;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign rec.score = new_score;
  assign rec.rooms = rooms;
  assign rec.stamp = stamp;
  assign rec.name  = name_tag;

  tkst_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .upd     (accept),
    .op      (op_t'(op)),
    .rec     (rec),
    .resumed (resumed),
    .slot    (slot),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      placed      <= res.placed;
      place       <= res.place;
      entry_score <= res.entry.score;
      entry_rooms <= res.entry.rooms;
      entry_stamp <= res.entry.stamp;
      entry_name  <= res.entry.name;
      is_latest   <= res.is_latest;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_place_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && placed) |-> (32'(place) < 32'(ENTRIES)))
    else $error("place outside table");

  a_offer_result_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && placed) |-> (entry_score == '0 && entry_name == '0 && !is_latest))
    else $error("offer result carries read fields");

  a_read_result_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_latest) |-> (!placed && place == '0))
    else $error("read result carries offer fields");

endmodule
